[design/kbm_pkg.sv]
package kbm_pkg;

  localparam int KW_TABLE_SIZE = 41;
  localparam int KEYWORD_COUNT = 41;
  localparam int KW_SCAN = (KEYWORD_COUNT < KW_TABLE_SIZE) ? KEYWORD_COUNT : KW_TABLE_SIZE;
  localparam int KW_MAX_LEN = 9;
  localparam int KW_IDX_W = 6;
  localparam logic [KW_IDX_W-1:0] KW_IDX_NONE = '1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef logic [8*KW_MAX_LEN-1:0] kw_text_t;

  // Each keyword sits right-justified: byte 0 is its final character, byte j the
  // character j places before it.
  localparam kw_text_t KW_TEXT [KW_TABLE_SIZE] = '{
    72'h68747470,
    72'h636f6d,
    72'h6e6574,
    72'h6f7267,
    72'h7275,
    72'h6e6f2d6970,
    72'h777777,
    72'h62697a,
    72'h7375,
    72'h636b,
    72'h7561,
    72'h7773,
    72'h2e696e666f,
    72'h2e6c74,
    72'h2e7a6170746f,
    72'h2d776f77,
    72'h776f772d,
    72'h776f77636972636c65,
    72'h776f77636972636c65,
    72'h75776f77,
    72'h697365_6e67617264,
    72'h73776f77,
    72'h616c646f72616e,
    72'h776f772d636f6f6c,
    72'h656c697465,
    72'h6d61676963,
    72'h6d6967,
    72'h7369727573,
    72'h636c6e,
    72'h656c677261636961,
    72'h7561776f77,
    72'h747572626f776f77,
    72'h73707a6f6e65,
    72'h66616b65776f77,
    72'h6261636b6b6f72,
    72'h6c657473776f77,
    72'h697a626f6f73686b61,
    72'h646561746873696465,
    72'h776172736f6e67,
    72'h726976657272697365,
    72'h726f6e646f72
  };

  localparam logic [3:0] KW_LEN [KW_TABLE_SIZE] = '{
    4'd4, 4'd3, 4'd3, 4'd3, 4'd2, 4'd5, 4'd3, 4'd3, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd5, 4'd3, 4'd6, 4'd4, 4'd4, 4'd9, 4'd9, 4'd4,
    4'd8, 4'd4, 4'd7, 4'd8, 4'd5, 4'd5, 4'd3, 4'd5, 4'd3, 4'd8,
    4'd5, 4'd8, 4'd6, 4'd7, 4'd7, 4'd7, 4'd9, 4'd9, 4'd7, 4'd9,
    4'd6
  };

  typedef struct packed {
    logic                hit;
    logic [KW_IDX_W-1:0] kw_idx;
    logic                last;
    logic                exempt;
  } kbm_class_t;

endpackage

[design/kbm_front.sv]
module kbm_front
  import kbm_pkg::*;
#(
  parameter int MAX_KEYWORD_LEN = 9
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       q_ready,
  input  logic [7:0] msg_byte,
  input  logic       last_byte,
  input  logic       sender_privileged,
  input  logic       addon_message,
  output logic       push,
  output kbm_class_t push_word
);

  localparam int WD = (MAX_KEYWORD_LEN - 1 < KW_MAX_LEN - 1) ?
                      (MAX_KEYWORD_LEN - 1) : (KW_MAX_LEN - 1);

  logic [7:0] window_r   [WD];
  logic [7:0] window_nxt [WD];
  logic [7:0] win_ext    [KW_MAX_LEN-1];
  logic [7:0] folded;
  logic [KW_SCAN-1:0] hit_vec;
  logic [KW_IDX_W-1:0] hit_idx;

  assign folded = (msg_byte >= CHAR_UPPER_A && msg_byte <= CHAR_UPPER_Z) ?
                  (msg_byte + CASE_OFFSET) : msg_byte;

  for (genvar gi = 0; gi < KW_MAX_LEN - 1; gi++) begin : g_win
    if (gi < WD) begin : g_live
      assign win_ext[gi] = window_r[gi];
    end else begin : g_zero
      assign win_ext[gi] = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < KW_SCAN; k++) begin
      hit_vec[k] = (KW_LEN[k] != 4'd0) && (int'(KW_LEN[k]) <= MAX_KEYWORD_LEN) &&
                   (folded == KW_TEXT[k][7:0]);
      for (int j = 1; j < KW_MAX_LEN; j++) begin
        if (j < int'(KW_LEN[k]) && win_ext[j-1] != KW_TEXT[k][8*j +: 8]) begin
          hit_vec[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int k = KW_SCAN - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        hit_idx = KW_IDX_W'(k);
      end
    end
  end

  always_comb begin
    window_nxt[0] = folded;
    for (int i = 1; i < WD; i++) begin
      window_nxt[i] = window_r[i-1];
    end
    if (last_byte) begin
      for (int i = 0; i < WD; i++) begin
        window_nxt[i] = '0;
      end
    end
  end

  assign push = in_valid && q_ready;

  always_comb begin
    push_word.hit    = |hit_vec;
    push_word.kw_idx = hit_idx;
    push_word.last   = last_byte;
    push_word.exempt = sender_privileged | addon_message;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WD; i++) begin
        window_r[i] <= '0;
      end
    end else if (push) begin
      window_r <= window_nxt;
    end
  end

endmodule

[design/kbm_queue.sv]
module kbm_queue
  import kbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  kbm_class_t push_word,
  output logic       q_ready,
  input  logic       pop,
  output logic       q_valid,
  output kbm_class_t q_word
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  kbm_class_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_ready = (count_r < CW'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_word  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

[design/kbm_back.sv]
module kbm_back
  import kbm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                q_valid,
  input  kbm_class_t          q_word,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_blocked,
  output logic [KW_IDX_W-1:0] out_kw
);

  logic                filter_en_r;
  logic                seen_r, seen_nxt;
  logic [KW_IDX_W-1:0] best_r, best_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_blocked_r, out_blocked_nxt;
  logic [KW_IDX_W-1:0] out_kw_r, out_kw_nxt;
  logic                seen_cur;
  logic [KW_IDX_W-1:0] best_cur;

  // A word that closes a message needs the output register free or draining.
  assign pop = q_valid && (!q_word.last || !out_valid_r || out_ready);

  assign seen_cur = seen_r | q_word.hit;
  assign best_cur = (q_word.hit && q_word.kw_idx < best_r) ? q_word.kw_idx : best_r;

  always_comb begin
    seen_nxt        = seen_r;
    best_nxt        = best_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_blocked_nxt = out_blocked_r;
    out_kw_nxt      = out_kw_r;
    if (pop) begin
      if (q_word.last) begin
        out_valid_nxt   = 1'b1;
        out_blocked_nxt = seen_cur && filter_en_r && !q_word.exempt;
        out_kw_nxt      = (seen_cur && filter_en_r && !q_word.exempt) ? best_cur : '0;
        seen_nxt        = 1'b0;
        best_nxt        = KW_IDX_NONE;
      end else begin
        seen_nxt = seen_cur;
        best_nxt = best_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b0;
      seen_r      <= 1'b0;
      best_r      <= KW_IDX_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        filter_en_r <= cfg_wdata;
      end
      seen_r      <= seen_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_blocked_r <= out_blocked_nxt;
    out_kw_r      <= out_kw_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_blocked = out_blocked_r;
  assign out_kw      = out_kw_r;

  a_kw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_blocked_r) |-> out_kw_r == '0)
    else $error("keyword number set on a passed message");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_word.last) |=> (!seen_r && best_r == KW_IDX_NONE))
    else $error("match state not cleared after last word");

  a_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_blocked_r) |-> filter_en_r)
    else $error("message blocked while filtering is off");

endmodule

[design/keyword_blacklist_matcher_top.sv]
// The verdict for a message's last byte goes through the queue and then into the output
// register, which loads it when free or draining; it is held there until taken.
// Throughput: one byte per cycle while the queue has room; the keyword comparators all work on the window at once.
// A two-word queue between the classifier and the verdict stage absorbs output stalls.
// Reset (synchronous, rst_n low) clears the window, the match state, the queue and
// the output valid flag, and turns filtering off.
module keyword_blacklist_matcher_top
  import kbm_pkg::*;
#(
  parameter int MAX_KEYWORD_LEN = 9
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] message_byte
  input  logic       in_tlast,   // last_byte
  input  logic [1:0] in_tuser,   // [0] sender_privileged, [1] addon_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] blocked, [6:1] keyword_number, [7] zero
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic                push;
  kbm_class_t          push_word;
  logic                q_ready;
  logic                q_valid;
  kbm_class_t          q_word;
  logic                pop;
  logic                blocked;
  logic [KW_IDX_W-1:0] kw_num;

  kbm_front #(
    .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .q_ready          (q_ready),
    .msg_byte         (in_tdata),
    .last_byte        (in_tlast),
    .sender_privileged(in_tuser[0]),
    .addon_message    (in_tuser[1]),
    .push             (push),
    .push_word        (push_word)
  );

  kbm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_word(push_word),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_word   (q_word)
  );

  kbm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_word     (q_word),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_blocked(blocked),
    .out_kw     (kw_num)
  );

  assign in_tready = q_ready;
  assign out_tdata = {1'b0, kw_num, blocked};

endmodule
